// ===== rtl/scba_pkg.sv =====
// Package for the size-class bitmap slot allocator.
// Sizes, widths, status codes, shared types and helper functions.
// No dependencies.
`default_nettype none

package scba_pkg;

    localparam int NUM_CLASSES     = 7;
    localparam int SLOTS_PER_CLASS = 256;
    localparam int WORDS_PER_CLASS = 8;
    localparam int NUM_CFG         = 7;

    localparam int SLOT_LIMIT = (SLOTS_PER_CLASS > WORDS_PER_CLASS * 32)
                              ? WORDS_PER_CLASS * 32 : SLOTS_PER_CLASS;

    localparam int SIZE_W   = 7;
    localparam int CLASS_W  = 3;
    localparam int SLOT_W   = 8;
    localparam int COUNT_W  = 9;
    localparam int STATUS_W = 2;
    localparam int CFG_IDX_W = 3;
    localparam int WORD_W   = (WORDS_PER_CLASS > 1) ? $clog2(WORDS_PER_CLASS) : 1;
    localparam int MEM_DEPTH = NUM_CLASSES * WORDS_PER_CLASS;
    localparam int ADDR_W   = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_FIT = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BAD    = 2'd3;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef logic [NUM_CLASSES-1:0][SIZE_W-1:0] size_arr_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [31:0]       wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } mem_req_t;

    function automatic logic [SIZE_W-1:0] size_reset(input int i);
        logic [SIZE_W-1:0] v;
        case (i)
            0:       v = 7'd8;
            1:       v = 7'd16;
            2:       v = 7'd24;
            3:       v = 7'd32;
            4:       v = 7'd40;
            5:       v = 7'd48;
            6:       v = 7'd64;
            default: v = 7'd0;
        endcase
        return v;
    endfunction

    // bits of a word that lie past the last usable slot read as taken
    function automatic logic [31:0] word_pad(input logic [WORD_W-1:0] w);
        logic [31:0] m;
        m = '0;
        for (int b = 0; b < 32; b++) begin
            if (int'(w) * 32 + b >= SLOT_LIMIT) begin
                m[b] = 1'b1;
            end
        end
        return m;
    endfunction

    function automatic logic [ADDR_W-1:0] word_addr(input logic [CLASS_W-1:0] c,
                                                    input logic [WORD_W-1:0] w);
        return ADDR_W'(32'(c) * WORDS_PER_CLASS + 32'(w));
    endfunction

endpackage

`default_nettype wire

// ===== rtl/scba_bitmap_mem.sv =====
// Occupancy bitmap store: one synchronous RAM with a registered read.
// Per-word valid flags make never-written words read as zero after reset.
// Depends on scba_pkg.
`default_nettype none

module scba_bitmap_mem
    import scba_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire mem_req_t    req,
    output logic [31:0]      rdata
);

    logic [31:0]          mem [MEM_DEPTH];
    logic [MEM_DEPTH-1:0] vld_reg;
    logic [31:0]          rd_reg;
    logic                 rd_vld_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re)
        begin
            rd_reg <= mem[req.raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (req.we)
            begin
                vld_reg[req.waddr] <= 1'b1;
            end
            if (req.re)
            begin
                rd_vld_reg <= vld_reg[req.raddr];
            end
        end
    end

    assign rdata = rd_vld_reg ? rd_reg : '0;

endmodule

`default_nettype wire

// ===== rtl/scba_cfg_regs.sv =====
// Class size registers written through the configuration channel.
// Depends on scba_pkg.
`default_nettype none

module scba_cfg_regs
    import scba_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [SIZE_W-1:0]    cfg_data,
    output size_arr_t                 sizes
);

    size_arr_t size_reg;
    size_arr_t size_next;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        size_next = size_reg;
        if (cfg_valid && (32'(cfg_index) < NUM_CFG))
        begin
            size_next[cfg_index] = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CLASSES; i++)
            begin
                size_reg[i] <= size_reset(i);
            end
        end
        else
        begin
            size_reg <= size_next;
        end
    end

    // a class with no register keeps size zero and never fits
    always_comb
    begin
        for (int i = 0; i < NUM_CLASSES; i++)
        begin
            sizes[i] = (i < NUM_CFG) ? size_reg[i] : '0;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/scba_ctrl.sv =====
// Sequencer: class match, word pick, read-modify-write of the bitmap,
// per-class counts and word-full flags, and the result register.
// Depends on scba_pkg.
`default_nettype none

module scba_ctrl
    import scba_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic                opcode,
    input  wire logic [SIZE_W-1:0]   request_size,
    input  wire logic [CLASS_W-1:0]  free_class,
    input  wire logic [SLOT_W-1:0]   free_slot,
    input  wire size_arr_t           sizes,
    output mem_req_t                 mem_req,
    input  wire logic [31:0]         mem_rdata,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [STATUS_W-1:0]      status,
    output logic [CLASS_W-1:0]       granted_class,
    output logic [SLOT_W-1:0]        granted_slot,
    output logic [SIZE_W-1:0]        granted_size,
    output logic [COUNT_W-1:0]       class_in_use
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_DECODE = 2'd1;
    localparam logic [1:0] S_MODIFY = 2'd2;
    localparam logic [1:0] S_RESULT = 2'd3;

    logic [1:0] state_reg, state_next;

    logic                 op_reg;
    logic [SIZE_W-1:0]    req_reg;
    logic [CLASS_W-1:0]   fcls_reg;
    logic [SLOT_W-1:0]    fslot_reg;

    logic [CLASS_W-1:0]   cls_reg, cls_next;
    logic [WORD_W-1:0]    word_reg, word_next;

    logic [STATUS_W-1:0]  rs_status_reg, rs_status_next;
    logic [CLASS_W-1:0]   rs_class_reg, rs_class_next;
    logic [SLOT_W-1:0]    rs_slot_reg, rs_slot_next;
    logic [SIZE_W-1:0]    rs_size_reg, rs_size_next;
    logic [COUNT_W-1:0]   rs_used_reg, rs_used_next;

    logic                 out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]  out_status_reg, out_status_next;
    logic [CLASS_W-1:0]   out_class_reg, out_class_next;
    logic [SLOT_W-1:0]    out_slot_reg, out_slot_next;
    logic [SIZE_W-1:0]    out_size_reg, out_size_next;
    logic [COUNT_W-1:0]   out_used_reg, out_used_next;

    logic [COUNT_W-1:0]         cnt_reg  [NUM_CLASSES];
    logic [COUNT_W-1:0]         cnt_next [NUM_CLASSES];
    logic [WORDS_PER_CLASS-1:0] full_reg  [NUM_CLASSES];
    logic [WORDS_PER_CLASS-1:0] full_next [NUM_CLASSES];

    logic                 fit_found;
    logic [CLASS_W-1:0]   fit_cls;
    logic                 word_found;
    logic [WORD_W-1:0]    word_sel;
    logic                 free_bad;

    logic [31:0]          pad;
    logic [31:0]          cur_word;
    logic [31:0]          new_word;
    logic [4:0]           zero_bit;
    logic [4:0]           bit_idx;
    logic [COUNT_W-1:0]   cnt_cur;
    logic [COUNT_W-1:0]   cnt_new;

    assign in_ready = (state_reg == S_IDLE);

    // first class whose size covers the request
    always_comb
    begin
        fit_found = 1'b0;
        fit_cls   = '0;
        for (int i = NUM_CLASSES - 1; i >= 0; i--)
        begin
            if (req_reg <= sizes[i])
            begin
                fit_found = 1'b1;
                fit_cls   = CLASS_W'(i);
            end
        end
    end

    // first word of that class with a free slot
    always_comb
    begin
        word_found = 1'b0;
        word_sel   = '0;
        for (int i = WORDS_PER_CLASS - 1; i >= 0; i--)
        begin
            if (!(full_reg[fit_cls][i] || (&word_pad(WORD_W'(i)))))
            begin
                word_found = 1'b1;
                word_sel   = WORD_W'(i);
            end
        end
    end

    assign free_bad = (32'(fcls_reg) >= NUM_CLASSES) || (32'(fslot_reg) >= SLOT_LIMIT);

    assign pad      = word_pad(word_reg);
    assign cur_word = mem_rdata;
    assign cnt_cur  = cnt_reg[cls_reg];

    always_comb
    begin
        zero_bit = '0;
        for (int b = 31; b >= 0; b--)
        begin
            if (!(cur_word[b] || pad[b]))
            begin
                zero_bit = 5'(b);
            end
        end
    end

    assign bit_idx = (op_reg == OP_ALLOC) ? zero_bit : fslot_reg[4:0];

    always_comb
    begin
        if (op_reg == OP_ALLOC)
        begin
            new_word = cur_word | (32'd1 << bit_idx);
            cnt_new  = (32'(cnt_cur) < SLOTS_PER_CLASS) ? cnt_cur + 1'b1 : cnt_cur;
        end
        else
        begin
            new_word = cur_word & ~(32'd1 << bit_idx);
            cnt_new  = (cnt_cur != '0) ? cnt_cur - 1'b1 : cnt_cur;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cls_next       = cls_reg;
        word_next      = word_reg;
        rs_status_next = rs_status_reg;
        rs_class_next  = rs_class_reg;
        rs_slot_next   = rs_slot_reg;
        rs_size_next   = rs_size_reg;
        rs_used_next   = rs_used_reg;
        cnt_next       = cnt_reg;
        full_next      = full_reg;
        mem_req        = '0;

        out_valid_next  = out_valid_reg && !out_ready;
        out_status_next = out_status_reg;
        out_class_next  = out_class_reg;
        out_slot_next   = out_slot_reg;
        out_size_next   = out_size_reg;
        out_used_next   = out_used_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                rs_status_next = ST_OK;
                rs_class_next  = '0;
                rs_slot_next   = '0;
                rs_size_next   = '0;
                rs_used_next   = '0;
                if (op_reg == OP_ALLOC)
                begin
                    if ((req_reg == '0) || !fit_found)
                    begin
                        rs_status_next = ST_NO_FIT;
                        state_next     = S_RESULT;
                    end
                    else if (!word_found)
                    begin
                        rs_status_next = ST_FULL;
                        rs_class_next  = fit_cls;
                        rs_used_next   = cnt_reg[fit_cls];
                        state_next     = S_RESULT;
                    end
                    else
                    begin
                        cls_next      = fit_cls;
                        word_next     = word_sel;
                        mem_req.re    = 1'b1;
                        mem_req.raddr = word_addr(fit_cls, word_sel);
                        state_next    = S_MODIFY;
                    end
                end
                else
                begin
                    if (free_bad)
                    begin
                        rs_status_next = ST_BAD;
                        state_next     = S_RESULT;
                    end
                    else
                    begin
                        cls_next      = fcls_reg;
                        word_next     = WORD_W'(fslot_reg >> 5);
                        mem_req.re    = 1'b1;
                        mem_req.raddr = word_addr(fcls_reg, WORD_W'(fslot_reg >> 5));
                        state_next    = S_MODIFY;
                    end
                end
            end
            S_MODIFY:
            begin
                mem_req.we             = 1'b1;
                mem_req.waddr          = word_addr(cls_reg, word_reg);
                mem_req.wdata          = new_word;
                cnt_next[cls_reg]      = cnt_new;
                full_next[cls_reg][word_reg] = &(new_word | pad);
                rs_status_next = ST_OK;
                rs_class_next  = cls_reg;
                rs_slot_next   = SLOT_W'({word_reg, bit_idx});
                rs_size_next   = sizes[cls_reg];
                rs_used_next   = cnt_new;
                state_next     = S_RESULT;
            end
            S_RESULT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = rs_status_reg;
                    out_class_next  = rs_class_reg;
                    out_slot_next   = rs_slot_reg;
                    out_size_next   = rs_size_reg;
                    out_used_next   = rs_used_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_CLASSES; i++)
            begin
                cnt_reg[i]  <= '0;
                full_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
            full_reg      <= full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            op_reg    <= opcode;
            req_reg   <= request_size;
            fcls_reg  <= free_class;
            fslot_reg <= free_slot;
        end
        cls_reg        <= cls_next;
        word_reg       <= word_next;
        rs_status_reg  <= rs_status_next;
        rs_class_reg   <= rs_class_next;
        rs_slot_reg    <= rs_slot_next;
        rs_size_reg    <= rs_size_next;
        rs_used_reg    <= rs_used_next;
        out_status_reg <= out_status_next;
        out_class_reg  <= out_class_next;
        out_slot_reg   <= out_slot_next;
        out_size_reg   <= out_size_next;
        out_used_reg   <= out_used_next;
    end

    assign out_valid     = out_valid_reg;
    assign status        = out_status_reg;
    assign granted_class = out_class_reg;
    assign granted_slot  = out_slot_reg;
    assign granted_size  = out_size_reg;
    assign class_in_use  = out_used_reg;

endmodule

`default_nettype wire

// ===== rtl/size_class_bitmap_slot_allocator.sv =====
// Top level of the size-class bitmap slot allocator.
// Instantiates scba_cfg_regs, scba_bitmap_mem and scba_ctrl; uses scba_pkg.
//
//  channel   dir   handshake             payload
//  s_*       in    s_tvalid / s_tready   request item: tuser opcode, tdata fields
//  m_*       out   m_tvalid / m_tready   result item: tuser status, tdata fields
//  cfg_*     in    cfg_valid / cfg_ready class size register write
//
// An item that touches the bitmap goes through accept, class match and word pick
// with bitmap read, read-modify-write of the word, and result load. A rejected
// item or a full class skips the bitmap access. The next item is accepted
// only after the result load; the sequencer takes one item at a time.
// Reset is asynchronous; the bitmap reads as all free through per-word valid
// flags, so there is no clearing pass. A stalled result waits in the output
// register while the next item is taken; that item's result waits behind it.
`default_nettype none

module size_class_bitmap_slot_allocator
    import scba_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // request_size[6:0], free_class[9:7], free_slot[17:10], zero
    input  wire logic [23:0]          s_tdata,
    input  wire logic                 s_tuser,  // opcode[0]
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // granted_class[2:0], granted_slot[10:3], granted_size[17:11],
    // class_in_use[26:18], zero
    output logic [31:0]               m_tdata,
    output logic [STATUS_W-1:0]       m_tuser,  // status[1:0]
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [SIZE_W-1:0]    cfg_data
);

    size_arr_t            sizes;
    mem_req_t             mem_req;
    logic [31:0]          mem_rdata;
    logic [CLASS_W-1:0]   granted_class;
    logic [SLOT_W-1:0]    granted_slot;
    logic [SIZE_W-1:0]    granted_size;
    logic [COUNT_W-1:0]   class_in_use;

    scba_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sizes     (sizes)
    );

    scba_bitmap_mem u_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mem_req),
        .rdata (mem_rdata)
    );

    scba_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .opcode        (s_tuser),
        .request_size  (s_tdata[6:0]),
        .free_class    (s_tdata[9:7]),
        .free_slot     (s_tdata[17:10]),
        .sizes         (sizes),
        .mem_req       (mem_req),
        .mem_rdata     (mem_rdata),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .status        (m_tuser),
        .granted_class (granted_class),
        .granted_slot  (granted_slot),
        .granted_size  (granted_size),
        .class_in_use  (class_in_use)
    );

    assign m_tdata = {5'd0, class_in_use, granted_size, granted_slot, granted_class};

endmodule

`default_nettype wire

// ===== rtl/scba_checker.sv =====
// Port-level checks for the slot allocator, bound to the top level.
// Depends on scba_pkg and size_class_bitmap_slot_allocator.
`default_nettype none

module scba_checker
    import scba_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    input  wire logic                 s_tready,
    input  wire logic [23:0]          s_tdata,
    input  wire logic                 s_tuser,
    input  wire logic                 m_tvalid,
    input  wire logic                 m_tready,
    input  wire logic [31:0]          m_tdata,
    input  wire logic [STATUS_W-1:0]  m_tuser,
    input  wire logic                 cfg_valid,
    input  wire logic                 cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [SIZE_W-1:0]    cfg_data
);

    // held result stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // one item at a time
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("item accepted while busy");

    // errors grant no size
    a_err_size: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != ST_OK) |-> m_tdata[17:11] == 7'd0)
        else $error("size granted on error");

    // no fit and bad class carry all-zero fields
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && ((m_tuser == ST_NO_FIT) || (m_tuser == ST_BAD)) |-> m_tdata == 32'd0)
        else $error("nonzero fields on rejected item");

endmodule

bind size_class_bitmap_slot_allocator scba_checker u_scba_checker (.*);

`default_nettype wire

// ===== tb/tb_size_class_bitmap_slot_allocator.sv =====
// Testbench for size_class_bitmap_slot_allocator: directed and random allocate/free
// traffic, checked item by item against an in-bench bitmap/count predictor.
// Depends on rtl/scba_pkg.sv and rtl/size_class_bitmap_slot_allocator.sv.
`default_nettype none

module tb_size_class_bitmap_slot_allocator;
    import scba_pkg::*;

    localparam int CYCLE_LIMIT         = 400000;
    localparam int HOLD_CYCLES         = 300;
    localparam int SETTLE_CYCLES       = 8;
    localparam int IDLE_PCT            = 16;
    localparam int REG_CLASS_SIZE_BASE = 0;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [CLASS_W-1:0]  cls;
        logic [SLOT_W-1:0]   slot;
        logic [SIZE_W-1:0]   size;
        logic [COUNT_W-1:0]  in_use;
    } grant_t;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [23:0]          s_tdata;   // request_size[6:0], free_class[9:7], free_slot[17:10], zero
    logic                 s_tuser;   // opcode[0]
    logic                 m_tvalid;
    logic                 m_tready;
    logic [31:0]          m_tdata;   // granted_class[2:0], granted_slot[10:3], granted_size[17:11],
                                     // class_in_use[26:18], zero
    logic [STATUS_W-1:0]  m_tuser;   // status[1:0]
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [SIZE_W-1:0]    cfg_data;

    // predictor state
    logic [SIZE_W-1:0]     class_size_model [NUM_CLASSES];
    logic [SLOT_LIMIT-1:0] slot_taken       [NUM_CLASSES];
    logic [COUNT_W-1:0]    in_use_model     [NUM_CLASSES];
    grant_t                pending_grants   [$];

    grant_t want_grant;
    grant_t got_grant;
    int     mismatch_count;
    int     cycle_count;
    bit     steady_mode;
    int     hold_asked;
    int     hold_done;

    size_class_bitmap_slot_allocator u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 clk = ~clk;

    function automatic grant_t predict_grant(input logic op,
                                             input logic [SIZE_W-1:0] req,
                                             input logic [CLASS_W-1:0] fcls,
                                             input logic [SLOT_W-1:0] fslot);
        grant_t g;
        int     pick;
        int     s;
        g = '0;
        pick = -1;
        s = -1;
        if (op == OP_ALLOC) begin
            if (req == '0) begin
                g.status = ST_NO_FIT;
                return g;
            end
            for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
                if (req <= class_size_model[c]) begin
                    pick = c;
                end
            end
            if (pick < 0) begin
                g.status = ST_NO_FIT;
                return g;
            end
            for (int k = SLOT_LIMIT - 1; k >= 0; k--) begin
                if (!slot_taken[pick][k]) begin
                    s = k;
                end
            end
            g.cls = CLASS_W'(pick);
            if (s < 0) begin
                g.status = ST_FULL;
                g.in_use = in_use_model[pick];
                return g;
            end
            slot_taken[pick][s] = 1'b1;
            if (in_use_model[pick] < SLOTS_PER_CLASS) begin
                in_use_model[pick] = in_use_model[pick] + 1'b1;
            end
            g.status = ST_OK;
            g.slot   = SLOT_W'(s);
            g.size   = class_size_model[pick];
            g.in_use = in_use_model[pick];
            return g;
        end
        if (fcls >= NUM_CLASSES || fslot >= SLOT_LIMIT) begin
            g.status = ST_BAD;
            return g;
        end
        slot_taken[fcls][fslot] = 1'b0;
        if (in_use_model[fcls] > 0) begin
            in_use_model[fcls] = in_use_model[fcls] - 1'b1;
        end
        g.status = ST_OK;
        g.cls    = fcls;
        g.slot   = fslot;
        g.size   = class_size_model[fcls];
        g.in_use = in_use_model[fcls];
        return g;
    endfunction

    task automatic send_request(input logic op, input logic [SIZE_W-1:0] req,
                                input logic [CLASS_W-1:0] fcls, input logic [SLOT_W-1:0] fslot);
        if (!steady_mode) begin
            while ($urandom_range(99) < IDLE_PCT) begin
                s_tvalid <= 1'b0;
                @(posedge clk);
            end
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {6'd0, fslot, fcls, req};
        do @(posedge clk); while (!s_tready);
        pending_grants.push_back(predict_grant(op, req, fcls, fslot));
    endtask

    task automatic request_alloc(input logic [SIZE_W-1:0] req);
        send_request(OP_ALLOC, req, CLASS_W'($urandom), SLOT_W'($urandom));
    endtask

    task automatic request_free(input logic [CLASS_W-1:0] fcls, input logic [SLOT_W-1:0] fslot);
        send_request(OP_FREE, SIZE_W'($urandom), fcls, fslot);
    endtask

    // stop offering items and let every outstanding result come back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_grants.size() != 0) begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic program_class_sizes(input size_arr_t sizes);
        for (int c = 0; c < NUM_CLASSES; c++) begin
            cfg_valid <= 1'b1;
            cfg_index <= CFG_IDX_W'(REG_CLASS_SIZE_BASE + c);
            cfg_data  <= sizes[c];
            do @(posedge clk); while (!cfg_ready);
            class_size_model[c] = sizes[c];
        end
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic check_field(input string what, input int want, input int got);
        if (want != got) begin
            mismatch_count++;
            $display("%0t: %s expected %0d actual %0d", $time, what, want, got);
        end
    endtask

    task automatic test_default_sizes();
        request_alloc(7'd0);
        request_alloc(7'd1);
        request_alloc(7'd8);
        request_alloc(7'd9);
        request_alloc(7'd16);
        request_alloc(7'd24);
        request_alloc(7'd32);
        request_alloc(7'd40);
        request_alloc(7'd48);
        request_alloc(7'd64);
        request_alloc(7'd65);
        request_alloc(7'd127);
        request_free(3'd7, 8'd0);
        request_free(3'd7, 8'd255);
        request_free(3'd0, 8'd0);
        request_free(3'd0, 8'd0);
        request_free(3'd3, 8'd255);
        request_free(3'd0, 8'd1);
        request_free(3'd0, 8'd1);
        request_alloc(7'd2);
        request_free(3'd6, 8'd0);
        drain_results();
    endtask

    task automatic test_size_extremes();
        program_class_sizes({7'd7, 7'd6, 7'd5, 7'd4, 7'd3, 7'd2, 7'd1});
        for (int b = 0; b <= 9; b++) begin
            request_alloc(SIZE_W'(b));
        end
        request_free(3'd6, 8'd0);
        request_free(3'd1, 8'd0);
        drain_results();
        program_class_sizes({7'd64, 7'd63, 7'd62, 7'd61, 7'd60, 7'd59, 7'd58});
        request_alloc(7'd1);
        request_alloc(7'd57);
        request_alloc(7'd58);
        request_alloc(7'd61);
        request_alloc(7'd64);
        request_alloc(7'd65);
        request_free(3'd0, 8'd0);
        request_free(3'd6, 8'd0);
        drain_results();
    endtask

    task automatic test_class_full();
        program_class_sizes({7'd64, 7'd48, 7'd40, 7'd32, 7'd24, 7'd16, 7'd8});
        steady_mode = 1'b1;
        for (int k = 0; k < SLOT_LIMIT + 3; k++) begin
            request_alloc(SIZE_W'($urandom_range(1, 8)));
        end
        request_free(3'd0, 8'd100);
        request_free(3'd0, 8'd37);
        request_free(3'd0, 8'd255);
        repeat (4) request_alloc(7'd8);
        for (int k = 0; k < SLOT_LIMIT; k++) begin
            request_free(3'd0, SLOT_W'(k));
        end
        request_free(3'd0, 8'd0);
        steady_mode = 1'b0;
        drain_results();
    endtask

    task automatic test_output_stall();
        hold_asked++;
        for (int k = 0; k < 40; k++) begin
            if ($urandom_range(1)) begin
                request_alloc(SIZE_W'($urandom_range(1, 64)));
            end else begin
                request_free(CLASS_W'($urandom_range(0, NUM_CLASSES - 1)), SLOT_W'($urandom_range(0, 3)));
            end
        end
        drain_results();
    endtask

    task automatic test_random_traffic(input int n_items);
        size_arr_t sizes;
        int        v;
        int        cls;
        int        start;
        int        hit;
        for (int i = 0; i < n_items; i++) begin
            if (i > 0 && i % 150 == 0) begin
                drain_results();
                v = $urandom_range(1, 12);
                for (int c = 0; c < NUM_CLASSES; c++) begin
                    sizes[c] = SIZE_W'(v);
                    v = v + $urandom_range(0, 10);
                    if (v > 64) v = 64;
                end
                if ($urandom_range(1)) sizes[NUM_CLASSES - 1] = 7'd64;
                program_class_sizes(sizes);
            end
            if ($urandom_range(99) < 55) begin
                v = $urandom_range(99);
                if (v < 5) begin
                    request_alloc(7'd0);
                end else if (v < 10) begin
                    request_alloc(SIZE_W'($urandom_range(65, 127)));
                end else begin
                    request_alloc(SIZE_W'($urandom_range(1, 64)));
                end
            end else if ($urandom_range(99) < 75) begin
                cls = $urandom_range(0, NUM_CLASSES - 1);
                start = $urandom_range(0, SLOT_LIMIT - 1);
                hit = start;
                for (int k = SLOT_LIMIT - 1; k >= 0; k--) begin
                    if (slot_taken[cls][(start + k) % SLOT_LIMIT]) hit = (start + k) % SLOT_LIMIT;
                end
                request_free(CLASS_W'(cls), SLOT_W'(hit));
            end else begin
                request_free(CLASS_W'($urandom_range(0, 7)), SLOT_W'($urandom_range(0, 255)));
            end
        end
        drain_results();
    endtask

    // result checker
    always @(posedge clk) begin
        if (rst_n && m_tvalid && m_tready) begin
            got_grant = {m_tuser, m_tdata[2:0], m_tdata[10:3], m_tdata[17:11], m_tdata[26:18]};
            if (pending_grants.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected result expected none actual %h", $time, got_grant);
            end else begin
                want_grant = pending_grants.pop_front();
                check_field("status", want_grant.status, got_grant.status);
                check_field("granted_class", want_grant.cls, got_grant.cls);
                check_field("granted_slot", want_grant.slot, got_grant.slot);
                check_field("granted_size", want_grant.size, got_grant.size);
                check_field("class_in_use", want_grant.in_use, got_grant.in_use);
            end
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("size_class_bitmap_slot_allocator regression: fail");
            $finish;
        end
    end

    // result receiver
    initial begin
        int n;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (hold_asked != hold_done) begin
                m_tready <= 1'b0;
                for (n = 0; n < HOLD_CYCLES; n++) begin
                    @(posedge clk);
                end
                hold_done++;
            end else begin
                m_tready <= steady_mode || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    initial begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = OP_ALLOC;
        cfg_valid      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        mismatch_count = 0;
        cycle_count    = 0;
        steady_mode    = 1'b0;
        hold_asked     = 0;
        hold_done      = 0;
        class_size_model = '{7'd8, 7'd16, 7'd24, 7'd32, 7'd40, 7'd48, 7'd64};
        for (int c = 0; c < NUM_CLASSES; c++) begin
            slot_taken[c]   = '0;
            in_use_model[c] = '0;
        end
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_sizes();
        test_size_extremes();
        test_class_full();
        test_output_stall();
        test_random_traffic(500);

        if (mismatch_count == 0) begin
            $display("size_class_bitmap_slot_allocator regression: pass");
        end else begin
            $display("size_class_bitmap_slot_allocator regression: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/scba_pkg.sv
rtl/scba_bitmap_mem.sv
rtl/scba_cfg_regs.sv
rtl/scba_ctrl.sv
rtl/size_class_bitmap_slot_allocator.sv
rtl/scba_checker.sv
tb/tb_size_class_bitmap_slot_allocator.sv
